FILE: src/burh_pkg.sv
package burh_pkg;

  // action codes carried in tuser
  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_UNDO  = 3'd1,
    ACT_REDO  = 3'd2,
    ACT_BEGIN = 3'd3,
    ACT_END   = 3'd4,
    ACT_CLEAR = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ENT_IN    = 2'd0,
    ENT_GROUP = 2'd1,
    ENT_REDO  = 2'd2
  } ent_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DROP,
    S_APPEND,
    S_EVICT,
    S_EVICT_DROP,
    S_UNDO_MV,
    S_REDO_LD,
    S_TOPS,
    S_OUT
  } state_e;

  localparam int unsigned TAG_W      = 16;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned IN_COST_W  = 24;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned BYTES_W    = 30;
  localparam int unsigned CFG_W      = 30;
  localparam int unsigned BYTE_FLOOR = 1024;

  localparam logic CFG_STEP_LIMIT = 1'b0;
  localparam logic CFG_BYTE_LIMIT = 1'b1;

  typedef struct packed {
    logic     load_in;
    logic     grp_apply;
    logic     ent_load;
    ent_sel_e ent_sel;
    logic     clear_redo;
    logic     rd_base;
    logic     rd_top;
    logic     drop;
    logic     append;
    logic     undo_move;
    logic     redo_pop;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       grp_active;
    logic       grp_nonempty;
    logic       undo_empty;
    logic       undo_full;
    logic       redo_empty;
    logic       redo_full;
    logic       evict_need;
    logic       out_busy;
  } status_t;

endpackage

FILE: src/burh_ctrl.sv
module burh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  burh_pkg::status_t sts_i,
  output burh_pkg::cmd_t   cmd_o
);

  burh_pkg::state_e state_q, state_d;
  logic commit;

  // push outside a group, or end of a non-empty group
  assign commit = ((sts_i.act == burh_pkg::ACT_PUSH) && !sts_i.grp_active) ||
                  ((sts_i.act == burh_pkg::ACT_END) && sts_i.grp_active &&
                   sts_i.grp_nonempty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= burh_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      burh_pkg::S_IDLE: begin
        if (in_valid_i) state_d = burh_pkg::S_EXEC;
      end
      burh_pkg::S_EXEC: begin
        if (commit) begin
          state_d = sts_i.undo_full ? burh_pkg::S_DROP : burh_pkg::S_APPEND;
        end else if ((sts_i.act == burh_pkg::ACT_UNDO) && !sts_i.undo_empty &&
                     !sts_i.redo_full) begin
          state_d = burh_pkg::S_UNDO_MV;
        end else if ((sts_i.act == burh_pkg::ACT_REDO) && !sts_i.redo_empty) begin
          state_d = burh_pkg::S_REDO_LD;
        end else begin
          state_d = burh_pkg::S_TOPS;
        end
      end
      burh_pkg::S_REDO_LD: begin
        state_d = sts_i.undo_full ? burh_pkg::S_DROP : burh_pkg::S_APPEND;
      end
      burh_pkg::S_DROP:       state_d = burh_pkg::S_APPEND;
      burh_pkg::S_APPEND: begin
        state_d = (sts_i.act == burh_pkg::ACT_REDO) ? burh_pkg::S_TOPS : burh_pkg::S_EVICT;
      end
      burh_pkg::S_EVICT: begin
        state_d = sts_i.evict_need ? burh_pkg::S_EVICT_DROP : burh_pkg::S_TOPS;
      end
      burh_pkg::S_EVICT_DROP: state_d = burh_pkg::S_EVICT;
      burh_pkg::S_UNDO_MV:    state_d = burh_pkg::S_TOPS;
      burh_pkg::S_TOPS:       state_d = burh_pkg::S_OUT;
      burh_pkg::S_OUT: begin
        if (!sts_i.out_busy) state_d = burh_pkg::S_IDLE;
      end
      default:                state_d = burh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.ent_sel = burh_pkg::ENT_IN;
    in_ready_o    = 1'b0;
    case (state_q)
      burh_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      burh_pkg::S_EXEC: begin
        cmd_o.grp_apply = 1'b1;
        if (commit) begin
          cmd_o.ent_load   = 1'b1;
          cmd_o.ent_sel    = (sts_i.act == burh_pkg::ACT_END) ? burh_pkg::ENT_GROUP
                                                               : burh_pkg::ENT_IN;
          cmd_o.clear_redo = 1'b1;
          cmd_o.rd_base    = 1'b1;
        end else begin
          cmd_o.rd_top = 1'b1;
        end
      end
      burh_pkg::S_REDO_LD: begin
        cmd_o.ent_load = 1'b1;
        cmd_o.ent_sel  = burh_pkg::ENT_REDO;
        cmd_o.redo_pop = 1'b1;
        cmd_o.rd_base  = 1'b1;
      end
      burh_pkg::S_DROP:       cmd_o.drop = 1'b1;
      burh_pkg::S_APPEND:     cmd_o.append = 1'b1;
      burh_pkg::S_EVICT:      cmd_o.rd_base = 1'b1;
      burh_pkg::S_EVICT_DROP: cmd_o.drop = 1'b1;
      burh_pkg::S_UNDO_MV:    cmd_o.undo_move = 1'b1;
      burh_pkg::S_TOPS:       cmd_o.rd_top = 1'b1;
      burh_pkg::S_OUT:        cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: src/burh_dp.sv
module burh_dp #(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned COST_BITS     = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [burh_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic [burh_pkg::ACT_W-1:0]        in_act_i,
  input  logic [burh_pkg::TAG_W-1:0]        in_tag_i,
  input  logic [burh_pkg::IN_COST_W-1:0]    in_cost_i,
  input  burh_pkg::cmd_t                    cmd_i,
  output burh_pkg::status_t                 sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [79:0]                       out_data_o
);

  localparam int unsigned PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > burh_pkg::STEP_W) ? CNT_W : burh_pkg::STEP_W;
  localparam int unsigned SUM_N  = COST_BITS + PTR_W + 1;
  localparam int unsigned SUM_W  = (SUM_N > 31) ? SUM_N : 31;
  localparam int unsigned ENT_W  = burh_pkg::TAG_W + COST_BITS;
  localparam logic [CNT_W-1:0]   DEPTH_C = CNT_W'(HISTORY_DEPTH);
  localparam logic [SUM_W-1:0]   BYTES_MAX = SUM_W'({burh_pkg::BYTES_W{1'b1}});

  logic [ENT_W-1:0] undo_mem [HISTORY_DEPTH];
  logic [ENT_W-1:0] redo_mem [HISTORY_DEPTH];

  logic [burh_pkg::STEP_W-1:0]  step_limit_q;
  logic [burh_pkg::CFG_W-1:0]   byte_limit_q;
  logic [burh_pkg::ACT_W-1:0]   act_q;
  logic [burh_pkg::TAG_W-1:0]   tag_q;
  logic [COST_BITS-1:0]         cost_q;
  logic [burh_pkg::TAG_W-1:0]   ent_tag_q;
  logic [COST_BITS-1:0]         ent_cost_q;
  logic [PTR_W-1:0]             base_q;
  logic [CNT_W-1:0]             udepth_q, rdepth_q;
  logic [SUM_W-1:0]             sum_q;
  logic                         grp_active_q, grp_nonempty_q;
  logic [burh_pkg::TAG_W-1:0]   grp_tag_q;
  logic [COST_BITS-1:0]         grp_bytes_q;
  logic [ENT_W-1:0]             urd_q, rrd_q;
  logic                         out_valid_q;
  logic [79:0]                  out_data_q;

  logic [PTR_W:0]   wr_raw, top_raw;
  logic [PTR_W-1:0] wr_slot, top_slot, urd_addr;
  logic [CMP_W-1:0] steps, sl_ext;
  logic [SUM_W-1:0] blim;
  logic [COST_BITS:0] grp_add;
  logic [COST_BITS-1:0] urd_cost;
  logic [SUM_W-1:0] hist_sat;
  logic [CMP_W-1:0] ucnt_ext, rcnt_ext;

  // ring slot arithmetic, modulo the depth
  always_comb begin
    wr_raw  = {1'b0, base_q} + (PTR_W+1)'(udepth_q);
    top_raw = wr_raw - (PTR_W+1)'(1);
    wr_slot  = (wr_raw  >= (PTR_W+1)'(HISTORY_DEPTH)) ?
               PTR_W'(wr_raw - (PTR_W+1)'(HISTORY_DEPTH)) : wr_raw[PTR_W-1:0];
    top_slot = (top_raw >= (PTR_W+1)'(HISTORY_DEPTH)) ?
               PTR_W'(top_raw - (PTR_W+1)'(HISTORY_DEPTH)) : top_raw[PTR_W-1:0];
    urd_addr = cmd_i.rd_base ? base_q : top_slot;
  end

  // clamped limits
  always_comb begin
    sl_ext = CMP_W'(step_limit_q);
    if (sl_ext == '0) begin
      steps = CMP_W'(1);
    end else if (sl_ext > CMP_W'(HISTORY_DEPTH)) begin
      steps = CMP_W'(HISTORY_DEPTH);
    end else begin
      steps = sl_ext;
    end
    blim = (byte_limit_q < burh_pkg::CFG_W'(burh_pkg::BYTE_FLOOR)) ?
           SUM_W'(burh_pkg::BYTE_FLOOR) : SUM_W'(byte_limit_q);
  end

  assign grp_add  = {1'b0, grp_bytes_q} + {1'b0, cost_q};
  assign urd_cost = urd_q[ENT_W-1:burh_pkg::TAG_W];

  always_comb begin
    sts_o.act          = act_q;
    sts_o.grp_active   = grp_active_q;
    sts_o.grp_nonempty = grp_nonempty_q;
    sts_o.undo_empty   = (udepth_q == '0);
    sts_o.undo_full    = (udepth_q == DEPTH_C);
    sts_o.redo_empty   = (rdepth_q == '0);
    sts_o.redo_full    = (rdepth_q == DEPTH_C);
    sts_o.evict_need   = (CMP_W'(udepth_q) > steps) ||
                         ((udepth_q != '0) && (sum_q > blim));
    sts_o.out_busy     = out_valid_q && !out_ready_i;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q <= burh_pkg::STEP_W'(64);
      byte_limit_q <= {burh_pkg::CFG_W{1'b1}};
    end else if (cfg_we_i) begin
      if (cfg_addr_i == burh_pkg::CFG_STEP_LIMIT) begin
        step_limit_q <= cfg_wdata_i[burh_pkg::STEP_W-1:0];
      end else begin
        byte_limit_q <= cfg_wdata_i;
      end
    end
  end

  // input and entry holding registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q  <= in_act_i;
      tag_q  <= in_tag_i;
      cost_q <= COST_BITS'(in_cost_i);
    end
    if (cmd_i.ent_load) begin
      case (cmd_i.ent_sel)
        burh_pkg::ENT_GROUP: begin
          ent_tag_q  <= grp_tag_q;
          ent_cost_q <= grp_bytes_q;
        end
        burh_pkg::ENT_REDO: begin
          ent_tag_q  <= rrd_q[burh_pkg::TAG_W-1:0];
          ent_cost_q <= rrd_q[ENT_W-1:burh_pkg::TAG_W];
        end
        default: begin
          ent_tag_q  <= tag_q;
          ent_cost_q <= cost_q;
        end
      endcase
    end
  end

  // history bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q         <= '0;
      udepth_q       <= '0;
      rdepth_q       <= '0;
      sum_q          <= '0;
      grp_active_q   <= 1'b0;
      grp_nonempty_q <= 1'b0;
      grp_tag_q      <= '0;
      grp_bytes_q    <= '0;
    end else begin
      if (cmd_i.grp_apply) begin
        case (act_q)
          burh_pkg::ACT_PUSH: begin
            if (grp_active_q) begin
              grp_bytes_q    <= grp_add[COST_BITS] ? {COST_BITS{1'b1}}
                                                   : grp_add[COST_BITS-1:0];
              grp_nonempty_q <= 1'b1;
            end
          end
          burh_pkg::ACT_BEGIN: begin
            grp_active_q   <= 1'b1;
            grp_tag_q      <= tag_q;
            grp_bytes_q    <= '0;
            grp_nonempty_q <= 1'b0;
          end
          burh_pkg::ACT_END: begin
            if (grp_active_q) begin
              grp_active_q   <= 1'b0;
              grp_bytes_q    <= '0;
              grp_nonempty_q <= 1'b0;
            end
          end
          burh_pkg::ACT_CLEAR: begin
            base_q         <= '0;
            udepth_q       <= '0;
            rdepth_q       <= '0;
            sum_q          <= '0;
            grp_active_q   <= 1'b0;
            grp_tag_q      <= '0;
            grp_bytes_q    <= '0;
            grp_nonempty_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.clear_redo) rdepth_q <= '0;
      if (cmd_i.redo_pop)   rdepth_q <= rdepth_q - CNT_W'(1);
      if (cmd_i.drop) begin
        base_q   <= (base_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : base_q + PTR_W'(1);
        udepth_q <= udepth_q - CNT_W'(1);
        sum_q    <= sum_q - SUM_W'(urd_cost);
      end
      if (cmd_i.append) begin
        udepth_q <= udepth_q + CNT_W'(1);
        sum_q    <= sum_q + SUM_W'(ent_cost_q);
      end
      if (cmd_i.undo_move) begin
        udepth_q <= udepth_q - CNT_W'(1);
        rdepth_q <= rdepth_q + CNT_W'(1);
        sum_q    <= sum_q - SUM_W'(urd_cost);
      end
    end
  end

  // history memories, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) undo_mem[wr_slot] <= {ent_cost_q, ent_tag_q};
    if (cmd_i.rd_base || cmd_i.rd_top) urd_q <= undo_mem[urd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.undo_move) redo_mem[rdepth_q[PTR_W-1:0]] <= urd_q;
    if (cmd_i.rd_top) begin
      rrd_q <= redo_mem[PTR_W'(rdepth_q - CNT_W'(1))];
    end
  end

  // result word
  always_comb begin
    hist_sat = (sum_q > BYTES_MAX) ? BYTES_MAX : sum_q;
    ucnt_ext = CMP_W'(udepth_q);
    rcnt_ext = CMP_W'(rdepth_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {1'b0,
                     grp_active_q,
                     hist_sat[burh_pkg::BYTES_W-1:0],
                     (rdepth_q != '0) ? rrd_q[burh_pkg::TAG_W-1:0] : 16'd0,
                     (rdepth_q != '0),
                     (udepth_q != '0) ? urd_q[burh_pkg::TAG_W-1:0] : 16'd0,
                     (udepth_q != '0),
                     rcnt_ext[burh_pkg::STEP_W-1:0],
                     ucnt_ext[burh_pkg::STEP_W-1:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_udepth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    udepth_q <= DEPTH_C) else $error("undo depth beyond ring size");
  a_rdepth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdepth_q <= DEPTH_C) else $error("redo depth beyond stack size");
  a_base_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q < PTR_W'(HISTORY_DEPTH - 1) || base_q == PTR_W'(HISTORY_DEPTH - 1))
    else $error("ring base out of range");
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    udepth_q == '0 |-> sum_q == '0) else $error("cost left on empty history");
  a_drop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |=> udepth_q == $past(udepth_q) - CNT_W'(1))
    else $error("eviction did not shrink history");

endmodule

FILE: src/bounded_undo_redo_history_unit.sv
// Bounded undo/redo history.
// Input words arrive on the s_axis channel: tuser carries the action (push,
// undo, redo, begin group, end group, clear), tdata the label tag and byte
// cost. Every accepted word yields exactly one status word on m_axis: both
// history depths, top labels, summed undo cost and the group-open flag.
// Configuration (step limit, byte budget) is written through cfg_we_i /
// cfg_addr_i / cfg_wdata_i; the user must write it only while the unit is
// idle, which the block does not enforce. It takes effect at the next commit.
// Each command passes through the sequencer states in turn: an undo adds a
// move step, a redo a load and append, a commit an append (after a drop when
// the ring is full) and the eviction walk over the ring (one memory read per
// dropped entry), which sets the worst case. One word is in flight at a time.
// s_axis_tready is high only while the sequencer waits in idle; it stays
// high while a finished result sits unclaimed in the output register.
// A receiver stall holds the next result in the sequencer until the output
// register frees.
// Reset empties both histories and group, sets the step limit to 64 and the byte
// budget to its maximum, drops any pending output word; memories are not cleared.
module bounded_undo_redo_history_unit #(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned COST_BITS     = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // fields from bit 0: entry_tag[15:0], entry_bytes[39:16]
  input  logic [39:0] s_axis_tdata,
  // fields from bit 0: action[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: undo_entries[6:0], redo_entries[13:7], undo_available[14],
  // undo_top_tag[30:15], redo_available[31], redo_top_tag[47:32],
  // history_bytes[77:48], grouping_open[78]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [29:0] cfg_wdata_i
);

  burh_pkg::cmd_t    cmd;
  burh_pkg::status_t sts;

  burh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  burh_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COST_BITS     (COST_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_act_i    (s_axis_tuser),
    .in_tag_i    (s_axis_tdata[15:0]),
    .in_cost_i   (s_axis_tdata[39:16]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
